// ===== sv/mvpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Majority-vote preamble deframer package
// Shared constants and the structs passed on by the vote and framer stages.
// ----------------------------------------------------------------------------
package mvpd_pkg;

	localparam int MAX_MESSAGE_BITS = 4096;
	// The bit counter must be able to hold MAX_MESSAGE_BITS itself.
	localparam int BIT_CNT_W = $clog2(MAX_MESSAGE_BITS + 1);

	localparam int LAT_W = 16;
	localparam int BYTE_W = 8;
	localparam int PRE_W = 6;

	localparam logic [PRE_W-1:0] PREAMBLE = 6'b101011;
	localparam logic [LAT_W-1:0] THRESH_RESET = 16'd100;
	localparam logic [LAT_W-1:0] COUNT_MAX = '1;
	localparam logic [BIT_CNT_W-1:0] MAX_BITS = BIT_CNT_W'(MAX_MESSAGE_BITS);

	// One decided bit, present only on a window end.
	typedef struct packed {
		logic valid;
		logic value;
	} bit_evt_t;

	// One result item, valid when the current sample produces output.
	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] byte_value;
		logic              eom;
	} result_t;

endpackage

// ===== sv/majority_vote_preamble_deframer_top.sv =====
// ----------------------------------------------------------------------------
// Majority-vote preamble deframer, top level
// Decides bits from latency samples, hunts the preamble and emits bytes.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carry one access_latency sample with its
// window_end flag per transaction. Output channel: out_valid/out_stall carry
// byte_value and end_of_message. The configuration channel cfg_valid/
// cfg_ready writes miss_threshold; cfg_ready is always high, and the write
// is meant to happen only while the block is idle.
// A sample is registered on acceptance; when it is processed, its result,
// if any, is loaded into the output register. One sample is taken every
// cycle as long as the output side keeps up; this is set by the update of
// the vote counters and framer state.
// Samples that produce no result keep flowing while a result waits. When
// a sample would produce a result and the output register is full and
// stalled, that sample waits in the input register and in_stall rises.
// Reset clears the counters, returns to preamble hunting, empties both
// registers and sets miss_threshold to 100.
// ----------------------------------------------------------------------------
module majority_vote_preamble_deframer_top
	import mvpd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [LAT_W-1:0]  access_latency,
	input  logic              window_end,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [BYTE_W-1:0] byte_value,
	output logic              end_of_message,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [LAT_W-1:0]  cfg_data
);

	logic [LAT_W-1:0]  threshold_q;
	logic              valid_s1;
	logic [LAT_W-1:0]  latency_s1;
	logic              wend_s1;
	logic              out_valid_q;
	logic [BYTE_W-1:0] byte_q;
	logic              eom_q;
	logic              go;
	logic              accept;
	bit_evt_t          bit_evt;
	result_t           result;

	assign cfg_ready = 1'b1;

	// A sample without a result never needs the output register.
	assign go = valid_s1 && (!result.valid || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !go;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			threshold_q <= THRESH_RESET;
		else if (cfg_valid)
			threshold_q <= cfg_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			latency_s1 <= access_latency;
			wend_s1 <= window_end;
		end
	end

	mvpd_vote u_vote (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.latency   (latency_s1),
		.wend      (wend_s1),
		.threshold (threshold_q),
		.bit_evt   (bit_evt)
	);

	mvpd_framer u_framer (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.bit_evt (bit_evt),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && result.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && result.valid) begin
			byte_q <= result.byte_value;
			eom_q <= result.eom;
		end
	end

	assign out_valid = out_valid_q;
	assign byte_value = byte_q;
	assign end_of_message = eom_q;

endmodule

// ===== sv/mvpd_vote.sv =====
// ----------------------------------------------------------------------------
// Majority-vote bit decision
// Counts hits and misses per bit window and decides the bit at window end.
// ----------------------------------------------------------------------------
module mvpd_vote
	import mvpd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [LAT_W-1:0] latency,
	input  logic             wend,
	input  logic [LAT_W-1:0] threshold,
	output bit_evt_t         bit_evt
);

	logic [LAT_W-1:0] miss_cnt_q;
	logic [LAT_W-1:0] hit_cnt_q;
	logic [LAT_W-1:0] miss_cnt_n;
	logic [LAT_W-1:0] hit_cnt_n;
	logic             is_miss;

	always_comb begin
		is_miss = latency > threshold;
		miss_cnt_n = miss_cnt_q;
		hit_cnt_n = hit_cnt_q;
		if (is_miss) begin
			if (miss_cnt_q != COUNT_MAX)
				miss_cnt_n = miss_cnt_q + 1'b1;
		end else begin
			if (hit_cnt_q != COUNT_MAX)
				hit_cnt_n = hit_cnt_q + 1'b1;
		end
		bit_evt.valid = wend;
		bit_evt.value = miss_cnt_n >= hit_cnt_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_cnt_q <= '0;
			hit_cnt_q <= '0;
		end else if (go) begin
			if (wend) begin
				miss_cnt_q <= '0;
				hit_cnt_q <= '0;
			end else begin
				miss_cnt_q <= miss_cnt_n;
				hit_cnt_q <= hit_cnt_n;
			end
		end
	end

endmodule

// ===== sv/mvpd_framer.sv =====
// ----------------------------------------------------------------------------
// Preamble hunt and byte framer
// Finds the preamble, then packs bits MSB first and flags the message end.
// ----------------------------------------------------------------------------
module mvpd_framer
	import mvpd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     go,
	input  bit_evt_t bit_evt,
	output result_t  result
);

	logic                 receiving_q;
	logic [PRE_W-1:0]     shift_q;
	logic [BIT_CNT_W-1:0] bit_cnt_q;
	logic [BYTE_W-1:0]    acc_q;

	logic                 receiving_n;
	logic [PRE_W-1:0]     shift_n;
	logic [BIT_CNT_W-1:0] bit_cnt_n;
	logic [BYTE_W-1:0]    acc_n;
	logic [PRE_W-1:0]     shift_new;
	logic [BYTE_W-1:0]    acc_new;
	logic [BIT_CNT_W-1:0] next_cnt;
	logic                 byte_done;

	always_comb begin
		receiving_n = receiving_q;
		shift_n = shift_q;
		bit_cnt_n = bit_cnt_q;
		acc_n = acc_q;
		result = '0;
		shift_new = {shift_q[PRE_W-2:0], bit_evt.value};
		acc_new = {acc_q[BYTE_W-2:0], bit_evt.value};
		next_cnt = bit_cnt_q + 1'b1;
		byte_done = next_cnt[2:0] == 3'd0;
		if (bit_evt.valid) begin
			if (!receiving_q) begin
				if (shift_new == PREAMBLE) begin
					receiving_n = 1'b1;
					shift_n = '0;
					bit_cnt_n = '0;
					acc_n = '0;
				end else begin
					shift_n = shift_new;
				end
			end else if ((byte_done && acc_new == '0) || next_cnt >= MAX_BITS) begin
				// Zero byte or bit limit: end marker, then hunt again.
				result.valid = 1'b1;
				result.eom = 1'b1;
				receiving_n = 1'b0;
				shift_n = '0;
				bit_cnt_n = '0;
				acc_n = '0;
			end else begin
				bit_cnt_n = next_cnt;
				if (byte_done) begin
					result.valid = 1'b1;
					result.byte_value = acc_new;
					acc_n = '0;
				end else begin
					acc_n = acc_new;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiving_q <= 1'b0;
			shift_q <= '0;
			bit_cnt_q <= '0;
			acc_q <= '0;
		end else if (go) begin
			receiving_q <= receiving_n;
			shift_q <= shift_n;
			bit_cnt_q <= bit_cnt_n;
			acc_q <= acc_n;
		end
	end

endmodule

// ===== tb/deframer_checker.sv =====
// ----------------------------------------------------------------------------
// Deframer checker
// Watches the sample, result and threshold channels of the majority-vote
// preamble deframer, predicts every output byte from the accepted samples and
// compares each result transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module deframer_checker
	import mvpd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [LAT_W-1:0]  access_latency,
	input  logic              window_end,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [BYTE_W-1:0] byte_value,
	input  logic              end_of_message,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [LAT_W-1:0]  cfg_data,
	output int                fail_count,
	output int                pending,
	output int                bytes_checked,
	output int                markers_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              eom;
	} deframed_byte_t;

	deframed_byte_t expected_bytes[$];
	deframed_byte_t want;

	// Shadow copy of the block state.
	logic [LAT_W-1:0]     threshold;
	logic [LAT_W-1:0]     misses;
	logic [LAT_W-1:0]     hits;
	logic [PRE_W-1:0]     hunt_shift;
	logic                 in_message;
	logic [BIT_CNT_W-1:0] bit_pos;
	logic [BYTE_W-1:0]    assembled;

	int mismatches;
	int data_seen;
	int markers_seen;

	function automatic void return_to_hunt();
		in_message = 1'b0;
		bit_pos = '0;
		assembled = '0;
		hunt_shift = '0;
	endfunction

	function automatic void vote_and_deframe(input logic [LAT_W-1:0] lat, input logic wend);
		logic              decided;
		int unsigned       next_pos;
		logic [BYTE_W-1:0] next_byte;
		deframed_byte_t    res;

		if (lat > threshold) begin
			if (misses != COUNT_MAX)
				misses = misses + 1'b1;
		end else if (hits != COUNT_MAX) begin
			hits = hits + 1'b1;
		end
		if (!wend)
			return;

		decided = (misses >= hits);
		misses = '0;
		hits = '0;

		if (!in_message) begin
			hunt_shift = {hunt_shift[PRE_W-2:0], decided};
			if (hunt_shift == PREAMBLE) begin
				return_to_hunt();
				in_message = 1'b1;
			end
			return;
		end

		next_byte = {assembled[BYTE_W-2:0], decided};
		next_pos = bit_pos + 1;
		// An aligned zero byte and the bit limit both close the message; at the
		// limit the byte holding the last bits is dropped.
		if ((next_pos % BYTE_W == 0 && next_byte == '0) || next_pos >= MAX_MESSAGE_BITS) begin
			res.data = '0;
			res.eom = 1'b1;
			expected_bytes.push_back(res);
			return_to_hunt();
			return;
		end
		bit_pos = next_pos[BIT_CNT_W-1:0];
		assembled = next_byte;
		if (next_pos % BYTE_W == 0) begin
			res.data = next_byte;
			res.eom = 1'b0;
			expected_bytes.push_back(res);
			assembled = '0;
		end
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 50)
			$display("MISMATCH at %0t ns: %s", $time, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold = THRESH_RESET;
			misses = '0;
			hits = '0;
			return_to_hunt();
			expected_bytes.delete();
			pending <= 0;
			fail_count <= mismatches;
		end else begin
			if (cfg_valid && cfg_ready)
				threshold = cfg_data;

			if (out_valid && !out_stall) begin
				if (expected_bytes.size() == 0) begin
					report_mismatch($sformatf("unexpected result byte %02h end %0b",
						byte_value, end_of_message));
				end else begin
					want = expected_bytes.pop_front();
					if (byte_value !== want.data)
						report_mismatch($sformatf("byte_value %02h, expected %02h",
							byte_value, want.data));
					if (end_of_message !== want.eom)
						report_mismatch($sformatf("end_of_message %0b, expected %0b",
							end_of_message, want.eom));
					if (want.eom)
						markers_seen++;
					else
						data_seen++;
				end
			end

			if (in_valid && !in_stall)
				vote_and_deframe(access_latency, window_end);

			pending <= expected_bytes.size();
			fail_count <= mismatches;
			bytes_checked <= data_seen;
			markers_checked <= markers_seen;
		end
	end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Majority-vote preamble deframer testbench
// Drives latency samples in windows that vote known bits, builds preambles and
// messages under several miss thresholds, and lets the checker compare every
// output byte and end marker. The input idles and the output stalls at random.
// ----------------------------------------------------------------------------
module tb
	import mvpd_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD = 10;
	localparam int DRAIN_CYCLES = 4;
	localparam int WATCHDOG_LIMIT = 2000;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [LAT_W-1:0]  access_latency;
	logic              window_end;
	logic              out_valid;
	logic              out_stall;
	logic [BYTE_W-1:0] byte_value;
	logic              end_of_message;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [LAT_W-1:0]  cfg_data;

	int fail_count;
	int pending;
	int bytes_checked;
	int markers_checked;

	logic [LAT_W-1:0] thr_now = THRESH_RESET;
	int               samples_sent = 0;
	int               settings_used = 1;
	int               burst_left = 0;
	int               quiet_cycles = 0;
	logic [7:0]       stall_tick = '0;
	logic [1:0]       stall_mode = '0;

	majority_vote_preamble_deframer_top DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.access_latency (access_latency),
		.window_end     (window_end),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.byte_value     (byte_value),
		.end_of_message (end_of_message),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	deframer_checker u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.access_latency  (access_latency),
		.window_end      (window_end),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.byte_value      (byte_value),
		.end_of_message  (end_of_message),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.pending         (pending),
		.bytes_checked   (bytes_checked),
		.markers_checked (markers_checked)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// The receiver switches between stall patterns whenever the low seven bits of stall_tick are zero.
	always @(posedge clk) begin
		stall_tick <= stall_tick + 1'b1;
		if (stall_tick[6:0] == '0)
			stall_mode <= 2'($urandom_range(0, 3));
		case (stall_mode)
			2'd0: out_stall <= 1'b0;
			2'd1: out_stall <= 1'($urandom_range(0, 1));
			2'd2: out_stall <= (stall_tick[2:0] < 3'd5);
			default: out_stall <= ($urandom_range(0, 9) != 0);
		endcase
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_sample(input logic [LAT_W-1:0] lat, input logic wend);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 5);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 24);
		end
		burst_left--;
		in_valid <= 1'b1;
		access_latency <= lat;
		window_end <= wend;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		samples_sent++;
	endtask

	// A miss needs a latency strictly above the threshold; half the picks sit on
	// the boundary or at an extreme of the range.
	function automatic logic [LAT_W-1:0] pick_latency(input logic miss);
		int lo;
		int hi;
		lo = miss ? int'(thr_now) + 1 : 0;
		hi = miss ? int'(COUNT_MAX) : int'(thr_now);
		case ($urandom_range(0, 3))
			0: return LAT_W'(miss ? lo : hi);
			1: return LAT_W'(miss ? hi : lo);
			default: return LAT_W'($urandom_range(hi, lo));
		endcase
	endfunction

	function automatic logic [BYTE_W-1:0] pick_byte();
		case ($urandom_range(0, 5))
			0: return 8'hFF;
			1: return 8'h01;
			default: return BYTE_W'($urandom_range(255, 1));
		endcase
	endfunction

	// One vote window whose miss/hit mix decides the wanted bit; ties vote a one.
	task automatic send_bit(input logic b);
		int   n;
		int   r;
		int   misses_left;
		int   hits_left;
		logic as_miss;
		r = $urandom_range(0, 19);
		n = (r < 10) ? 1 : (r < 17) ? $urandom_range(2, 3) : $urandom_range(4, 9);
		misses_left = b ? $urandom_range(n, (n + 1) / 2) : $urandom_range((n - 1) / 2, 0);
		hits_left = n - misses_left;
		for (int i = n; i > 0; i--) begin
			as_miss = (misses_left > 0) && (hits_left == 0 || $urandom_range(0, 1) == 1);
			if (as_miss)
				misses_left--;
			else
				hits_left--;
			send_sample(pick_latency(as_miss), i == 1);
		end
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		for (int i = BYTE_W - 1; i >= 0; i--)
			send_bit(b[i]);
	endtask

	task automatic send_message(input int data_bytes, input logic close);
		for (int i = PRE_W - 1; i >= 0; i--)
			send_bit(PREAMBLE[i]);
		repeat (data_bytes) send_byte(pick_byte());
		if (close)
			send_byte(8'h00);
	endtask

	// Sixteen zero bits always contain an aligned zero byte, so the block ends up
	// hunting with an empty preamble history whatever state it was in.
	task automatic flush_to_hunt();
		repeat (2 * BYTE_W) send_bit(1'b0);
	endtask

	task automatic set_threshold(input logic [LAT_W-1:0] value);
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		thr_now = value;
		settings_used++;
	endtask

	task automatic run_random(input int count);
		int stop_at;
		int pick;
		int flip;
		stop_at = samples_sent + count;
		while (samples_sent < stop_at) begin
			// With the threshold at its maximum no sample can be a miss.
			pick = (thr_now == COUNT_MAX) ? 8 : $urandom_range(0, 9);
			case (pick)
				6: repeat ($urandom_range(12, 1)) send_bit(1'($urandom_range(0, 1)));
				7: begin
					flip = $urandom_range(0, PRE_W - 1);
					for (int i = PRE_W - 1; i >= 0; i--)
						send_bit(PREAMBLE[i] ^ (i == flip));
					send_byte(pick_byte());
				end
				8: repeat ($urandom_range(8, 1))
					send_sample(LAT_W'($urandom_range(65535, 0)), $urandom_range(0, 3) == 0);
				9: begin
					flush_to_hunt();
					send_message($urandom_range(3, 1), 1'b1);
				end
				default: send_message($urandom_range(3, 1), $urandom_range(0, 7) != 0);
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		access_latency = '0;
		window_end = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Preamble with boundary latencies around the reset threshold and one tied
		// two-sample window, which votes a one.
		send_sample(16'hFFFF, 1'b1);
		send_sample(16'd0, 1'b1);
		send_sample(THRESH_RESET + 16'd1, 1'b1);
		send_sample(THRESH_RESET, 1'b1);
		send_sample(16'd200, 1'b0);
		send_sample(16'd50, 1'b1);
		send_sample(16'hFFFF, 1'b1);
		// A byte with only the top bit set, then a zero byte that ends the message.
		for (int i = 0; i < 2 * BYTE_W; i++)
			send_sample((i == 0) ? 16'hFFFF : (i % 2 == 1) ? 16'd0 : THRESH_RESET, 1'b1);

		run_random(150);
		set_threshold(16'd0);
		run_random(150);
		set_threshold(COUNT_MAX);
		run_random(80);
		set_threshold(LAT_W'($urandom_range(65534, 1)));
		run_random(150);
		set_threshold(LAT_W'($urandom_range(500, 1)));
		run_random(150);
		set_threshold(THRESH_RESET);
		run_random(120);

		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d samples under %0d threshold settings as preambles, messages",
			samples_sent, settings_used);
		$display("and loose vote windows; %0d bytes and %0d end markers compared.",
			bytes_checked, markers_checked);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
